// ===== rtl/dpr_pkg.sv =====
// ============================================================================
// dpr_pkg
// Shared types, codes and character helpers of the debug packet receiver.
// ============================================================================
`default_nettype none

package dpr_pkg;

    localparam int unsigned ADDR_BITS_DEF = 32;
    localparam logic [15:0] READ_LIMIT_RESET = 16'd128;

    // framing characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] HEX_BAD   = 8'hff;

    // command class characters
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_M     = 8'h6d;
    localparam logic [7:0] CH_K     = 8'h6b;

    // event codes
    localparam logic [1:0] EV_BAD_SUM = 2'd0;
    localparam logic [1:0] EV_ACK     = 2'd1;
    localparam logic [1:0] EV_RESEND  = 2'd2;
    localparam logic [1:0] EV_NOSYNC  = 2'd3;

    // transmit bytes
    localparam logic [7:0] TX_ACK  = CH_PLUS;
    localparam logic [7:0] TX_NAK  = CH_MINUS;
    localparam logic [7:0] TX_NONE = 8'h00;

    // command kinds
    localparam logic [2:0] CMD_THREAD  = 3'd0;
    localparam logic [2:0] CMD_OFFSETS = 3'd1;
    localparam logic [2:0] CMD_QUERY   = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_REGS    = 3'd4;
    localparam logic [2:0] CMD_MEMREAD = 3'd5;
    localparam logic [2:0] CMD_KILL    = 3'd6;
    localparam logic [2:0] CMD_UNKNOWN = 3'd7;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  tx_byte;
        logic [2:0]  cmd_kind;
        logic [31:0] mem_address;
        logic [15:0] mem_length;
    } dpr_result_t;

    // hex digit value, 0xff for anything that is not a digit
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = HEX_BAD;
        if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
        else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
        else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
        return v;
    endfunction

    // text that follows 'q' in the offsets query
    function automatic logic [7:0] offsets_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h4f; // O
            3'd1:    c = 8'h66; // f
            3'd2:    c = 8'h66; // f
            3'd3:    c = 8'h73; // s
            3'd4:    c = 8'h65; // e
            3'd5:    c = 8'h74; // t
            3'd6:    c = 8'h73; // s
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dpr_if.sv =====
// ============================================================================
// dpr_if
// Valid/ready channels: received bytes in, framing events out.
// ============================================================================
`default_nettype none

interface dpr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface dpr_result_if;
    logic                valid;
    logic                ready;
    dpr_pkg::dpr_result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/dpr_framer.sv =====
// ============================================================================
// dpr_framer
// Packet framing state, payload sum and command field parsing, one byte a step.
// ============================================================================
`default_nettype none

module dpr_framer #(
    parameter int unsigned ADDR_BITS = dpr_pkg::ADDR_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic [7:0]           rx_byte,
    input  wire logic [15:0]          read_length_limit,
    output logic                      res_valid,
    output dpr_pkg::dpr_result_t      res_data
);
    import dpr_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_PAYLOAD = 3'd1;
    localparam logic [2:0] ST_CK1     = 3'd2;
    localparam logic [2:0] ST_CK2     = 3'd3;
    localparam logic [2:0] ST_WAITACK = 3'd4;
    localparam logic [2:0] ST_QUIT    = 3'd5;

    logic [2:0]           state_reg,   state_next;
    logic [7:0]           sum_reg,     sum_next;
    logic [3:0]           ck_high_reg, ck_high_next;
    logic                 ck_bad_reg,  ck_bad_next;
    logic [7:0]           first_reg,   first_next;
    logic [3:0]           pos_reg,     pos_next;
    logic                 mism_reg,    mism_next;
    logic                 ended_reg,   ended_next;
    logic                 in_len_reg,  in_len_next;
    logic [ADDR_BITS-1:0] addr_reg,    addr_next;
    logic [31:0]          len_reg,     len_next;

    logic [7:0]  nib;
    logic [2:0]  kind;
    logic [15:0] len_clamped;

    assign nib = hex_value(rx_byte);

    always_comb
    begin
        unique case (first_reg)
            CH_H:     kind = CMD_THREAD;
            CH_Q:     kind = (!mism_reg && pos_reg == 4'd8) ? CMD_OFFSETS : CMD_QUERY;
            CH_QMARK: kind = CMD_STOP;
            CH_G:     kind = CMD_REGS;
            CH_M:     kind = CMD_MEMREAD;
            CH_K:     kind = CMD_KILL;
            default:  kind = CMD_UNKNOWN;
        endcase
    end

    assign len_clamped = (len_reg > {16'h0, read_length_limit}) ? read_length_limit
                                                                 : len_reg[15:0];

    always_comb
    begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        ck_high_next = ck_high_reg;
        ck_bad_next  = ck_bad_reg;
        first_next   = first_reg;
        pos_next     = pos_reg;
        mism_next    = mism_reg;
        ended_next   = ended_reg;
        in_len_next  = in_len_reg;
        addr_next    = addr_reg;
        len_next     = len_reg;
        res_valid    = 1'b0;
        res_data     = '0;

        if (step)
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (rx_byte == CH_DOLLAR)
                    begin
                        state_next   = ST_PAYLOAD;
                        sum_next     = '0;
                        ck_high_next = '0;
                        ck_bad_next  = 1'b0;
                        first_next   = '0;
                        pos_next     = '0;
                        mism_next    = 1'b0;
                        ended_next   = 1'b0;
                        in_len_next  = 1'b0;
                        addr_next    = '0;
                        len_next     = '0;
                    end
                end
                ST_PAYLOAD:
                begin
                    if (rx_byte == CH_HASH)
                    begin
                        state_next = ST_CK1;
                    end
                    else if (!ended_reg)
                    begin
                        if (rx_byte == CH_NUL)
                        begin
                            ended_next = 1'b1;
                        end
                        else
                        begin
                            sum_next = sum_reg + rx_byte;
                            if (pos_reg == 4'd0)
                            begin
                                first_next = rx_byte;
                            end
                            else
                            begin
                                if (pos_reg > 4'd7
                                    || rx_byte != offsets_char(pos_reg[2:0] - 3'd1))
                                    mism_next = 1'b1;
                                if (in_len_reg)
                                    len_next = {len_reg[27:0], 4'h0} + 32'(nib);
                                else if (rx_byte == CH_COMMA)
                                    in_len_next = 1'b1;
                                else
                                    addr_next = {addr_reg[ADDR_BITS-5:0], 4'h0}
                                                + ADDR_BITS'(nib);
                            end
                            if (pos_reg != 4'hf)
                                pos_next = pos_reg + 4'd1;
                        end
                    end
                end
                ST_CK1:
                begin
                    if (nib == HEX_BAD)
                        ck_bad_next = 1'b1;
                    ck_high_next = nib[3:0];
                    state_next   = ST_CK2;
                end
                ST_CK2:
                begin
                    res_valid = 1'b1;
                    if (nib == HEX_BAD || ck_bad_reg || {ck_high_reg, nib[3:0]} != sum_reg)
                    begin
                        res_data.event_res = EV_BAD_SUM;
                        res_data.tx_byte   = TX_NAK;
                        state_next         = ST_IDLE;
                    end
                    else
                    begin
                        res_data.event_res = EV_ACK;
                        res_data.tx_byte   = TX_ACK;
                        res_data.cmd_kind  = kind;
                        if (kind == CMD_MEMREAD)
                        begin
                            res_data.mem_address = 32'(addr_reg);
                            res_data.mem_length  = len_clamped;
                        end
                        state_next = (kind == CMD_KILL) ? ST_QUIT : ST_WAITACK;
                    end
                end
                ST_WAITACK:
                begin
                    if (rx_byte == CH_PLUS)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (rx_byte == CH_MINUS)
                    begin
                        res_valid          = 1'b1;
                        res_data.event_res = EV_RESEND;
                        res_data.tx_byte   = TX_NONE;
                    end
                    else
                    begin
                        res_valid          = 1'b1;
                        res_data.event_res = EV_NOSYNC;
                        res_data.tx_byte   = TX_NAK;
                        state_next         = ST_IDLE;
                    end
                end
                default:
                begin
                    // quit, and the unused codes fold into quit
                    state_next = ST_QUIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            ck_high_reg <= '0;
            ck_bad_reg  <= 1'b0;
            first_reg   <= '0;
            pos_reg     <= '0;
            mism_reg    <= 1'b0;
            ended_reg   <= 1'b0;
            in_len_reg  <= 1'b0;
            addr_reg    <= '0;
            len_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            ck_high_reg <= ck_high_next;
            ck_bad_reg  <= ck_bad_next;
            first_reg   <= first_next;
            pos_reg     <= pos_next;
            mism_reg    <= mism_next;
            ended_reg   <= ended_next;
            in_len_reg  <= in_len_next;
            addr_reg    <= addr_next;
            len_reg     <= len_next;
        end
    end

    a_quit_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_QUIT |=> state_reg == ST_QUIT)
        else $error("framer left quit state");

    a_fields_only_for_read: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.cmd_kind != CMD_MEMREAD
        |-> res_data.mem_address == 32'h0 && res_data.mem_length == 16'h0)
        else $error("memory fields set outside a memory read ack");

    a_position_cap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PAYLOAD && pos_reg == 4'hf |=> pos_reg == 4'hf)
        else $error("payload position wrapped");

endmodule

`default_nettype wire

// ===== rtl/dpr_out_reg.sv =====
// ============================================================================
// dpr_out_reg
// Result register in front of the event channel.
// ============================================================================
`default_nettype none

module dpr_out_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire dpr_pkg::dpr_result_t load_data,
    output logic                      can_take,
    dpr_result_if.source              res
);
    import dpr_pkg::*;

    logic        valid_reg, valid_next;
    dpr_result_t data_reg;

    assign can_take = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (res.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign res.valid   = valid_reg;
    assign res.payload = data_reg;

endmodule

`default_nettype wire

// ===== rtl/debug_packet_receiver.sv =====
// ============================================================================
// debug_packet_receiver
// Framer for a remote-debug serial link: tracks '$payload#hh' packets and
// reports ack/nak, resend and command fields of each packet.
// ============================================================================
//
//  channel   dir   beat payload
//  -------   ---   ---------------------------------------------------------
//  rx        in    rx_byte, one received link byte
//  res       out   event_res, tx_byte, cmd_kind, mem_address, mem_length
//  cfg       in    cfg_we / cfg_data: read_length_limit, write only
//
//  One byte a cycle sustained. A byte goes to the input register, the framer
//  consumes it there, and its result reaches res via the result register.
//  The framer step waits only while the result register is full and res is
//  stalled; rx.ready drops then and the held byte waits in the input register.
//  Reset (rst_n low, async) returns to idle and sets the limit to 128.
//
`default_nettype none

module debug_packet_receiver #(
    parameter int unsigned ADDR_BITS = dpr_pkg::ADDR_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    dpr_byte_if.sink         rx,
    dpr_result_if.source     res,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data
);
    import dpr_pkg::*;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // configuration
    logic [15:0] limit_reg;

    logic        step;
    logic        out_can_take;
    logic        fr_valid;
    dpr_result_t fr_data;

    // the framer advances whenever a byte is held and the result slot is free
    assign step     = in_valid_reg && out_can_take;
    assign rx.ready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx.valid && rx.ready)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            limit_reg    <= READ_LIMIT_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_we)
                limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.payload;
    end

    dpr_framer #(
        .ADDR_BITS (ADDR_BITS)
    ) u_framer (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .rx_byte           (in_byte_reg),
        .read_length_limit (limit_reg),
        .res_valid         (fr_valid),
        .res_data          (fr_data)
    );

    dpr_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fr_valid),
        .load_data (fr_data),
        .can_take  (out_can_take),
        .res       (res)
    );

    a_len_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.payload.cmd_kind == CMD_MEMREAD
        |-> res.payload.mem_length <= limit_reg)
        else $error("memory read length above limit");

    a_ack_tx: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> ((res.payload.event_res == EV_ACK) == (res.payload.tx_byte == TX_ACK)))
        else $error("tx byte does not match event");

    a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held input byte lost");

endmodule

`default_nettype wire
